/* design/cses_pkg.sv */
package cses_pkg;

    localparam int NEST_DEPTH_DEF  = 64;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 20;

    typedef enum logic [3:0] {
        K_WHI = 4'd0,
        K_TOK = 4'd1,
        K_PRE = 4'd2,
        K_LCO = 4'd3,
        K_BCO = 4'd4,
        K_SEM = 4'd5,
        K_LBR = 4'd6,
        K_PAR = 4'd7,
        K_BRA = 4'd8,
        K_CUR = 4'd9,
        K_CLO = 4'd10,
        K_ASG = 4'd11,
        K_PUB = 4'd12,
        K_ERR = 4'd13,
        K_END = 4'd14
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_STRING   = 3'd1,
        E_CHAR     = 3'd2,
        E_COMMENT  = 3'd3,
        E_MISMATCH = 3'd4,
        E_OPEN     = 3'd5,
        E_OVERFLOW = 3'd6
    } t_err;

    typedef enum logic [8:0] {
        M_IDLE  = 9'b000000001,
        M_WHI   = 9'b000000010,
        M_TOK   = 9'b000000100,
        M_PRE   = 9'b000001000,
        M_SLASH = 9'b000010000,
        M_LCO   = 9'b000100000,
        M_BCO   = 9'b001000000,
        M_STR   = 9'b010000000,
        M_CHR   = 9'b100000000
    } t_mode;

    localparam logic [1:0] BR_PAR = 2'd0;
    localparam logic [1:0] BR_BRA = 2'd1;
    localparam logic [1:0] BR_CUR = 2'd2;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_DQ    = 8'h22;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_SQ    = 8'h27;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_LBRK  = 8'h5B;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_RBRK  = 8'h5D;
    localparam logic [7:0] C_LBRC  = 8'h7B;
    localparam logic [7:0] C_RBRC  = 8'h7D;

    function automatic logic f_tok_stop(input logic [7:0] c);
        return c == C_SP || c == C_TAB || c == C_NL || c == C_SEMI || c == C_EQ ||
               c == C_SLASH || c == C_BSL || c == C_DQ || c == C_SQ ||
               c == C_LPAR || c == C_LBRC || c == C_LBRK ||
               c == C_RPAR || c == C_RBRC || c == C_RBRK;
    endfunction

    function automatic logic [1:0] f_br_code(input logic [7:0] c);
        if (c == C_LPAR || c == C_RPAR) return BR_PAR;
        if (c == C_LBRK || c == C_RBRK) return BR_BRA;
        return BR_CUR;
    endfunction

    function automatic t_kind f_group_kind(input logic [1:0] code);
        t_kind k;
        case (code)
            BR_PAR:  k = K_PAR;
            BR_BRA:  k = K_BRA;
            default: k = K_CUR;
        endcase
        return k;
    endfunction

endpackage

/* design/cses_in_if.sv */
interface cses_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* design/cses_out_if.sv */
interface cses_out_if #(
    parameter int OFF_W  = 24,
    parameter int LINE_W = 20
);
    logic              valid;
    logic              ready;
    logic [3:0]        kind;
    logic [OFF_W-1:0]  begin_offset;
    logic [OFF_W-1:0]  length;
    logic [2:0]        error_code;
    logic [LINE_W-1:0] error_line;
    logic              last;

    modport source (output valid, output kind, output begin_offset, output length,
                    output error_code, output error_line, output last, input ready);
    modport sink (input valid, input kind, input begin_offset, input length,
                  input error_code, input error_line, input last, output ready);
endinterface

/* design/c_source_element_scanner.sv */
// Channel  Direction  Beat contents
// i_in     in         text_byte, end_of_text
// o_out    out        kind, begin_offset, length, error_code, error_line, last
//
// One input beat is taken per cycle while the input is ready; its results enter the
// queue at that edge and are offered from the next cycle on. Each beat yields zero to
// three result beats. The input is ready while at most one result is queued, so beats
// of at most one result each flow at one per cycle while the output takes them.
// Reset is synchronous and active low and leaves the scanner at the start of a text.
// A stall on the output side holds results in the queue and then stops the input.
module c_source_element_scanner
    import cses_pkg::*;
#(
    parameter int NEST_DEPTH  = NEST_DEPTH_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cses_in_if.sink    i_in,
    cses_out_if.source o_out
);

    localparam int NEST_W = $clog2(NEST_DEPTH + 1);
    localparam int ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int BR_W   = 2 + LINE_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LIN_MAX = {LINE_BITS{1'b1}};

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] beg;
        logic [OFFSET_BITS-1:0] len;
        t_err                   code;
        logic [LINE_BITS-1:0]   line;
        logic                   last;
    } t_res;

    function automatic t_res f_res(input t_kind k, input logic [OFFSET_BITS-1:0] b,
                                   input logic [OFFSET_BITS-1:0] e, input t_err code,
                                   input logic [LINE_BITS-1:0] line);
        t_res r;
        r.kind = k;
        r.beg  = b;
        r.len  = (e >= b) ? e - b : '0;
        r.code = code;
        r.line = line;
        r.last = 1'b0;
        return r;
    endfunction

    t_mode                  r_mode, n_mode;
    logic                   r_lsf, n_lsf, r_esc, n_esc, r_bsp, n_bsp, r_star, n_star;
    logic                   r_halt, n_halt;
    logic [NEST_W-1:0]      r_nest, n_nest;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_estart, n_estart;
    logic [LINE_BITS-1:0]   r_line, n_line, r_isl, n_isl;
    logic [BR_W-1:0]        r_stack [NEST_DEPTH];
    logic [BR_W-1:0]        r_top, n_top, r_below;
    logic                   push;
    logic [BR_W-1:0]        push_data;
    logic [NEST_W-1:0]      rd_addr;

    t_res                   res [3];
    logic [1:0]             cnt;
    logic                   consumed, run_start;
    logic [7:0]             c;
    logic                   eot;
    logic [OFFSET_BITS-1:0] pos_end, pos_prev;
    logic [1:0]             bc;

    t_res                   r_q [4];
    logic [1:0]             r_wp, r_rp;
    logic [2:0]             r_count;
    logic                   in_fire, out_fire;

    assign c        = i_in.text_byte;
    assign eot      = i_in.end_of_text || c == C_NUL;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign pos_end  = (r_pos < OFF_MAX) ? r_pos + 1'b1 : OFF_MAX;
    assign pos_prev = (r_pos != '0) ? r_pos - 1'b1 : '0;
    assign bc       = f_br_code(c);

    always_comb begin
        n_mode = r_mode; n_lsf = r_lsf; n_esc = r_esc; n_bsp = r_bsp; n_star = r_star;
        n_halt = r_halt; n_nest = r_nest; n_pos = r_pos; n_line = r_line;
        n_estart = r_estart; n_isl = r_isl; n_top = r_top;
        push = 1'b0; push_data = {bc, r_line};
        cnt = 2'd0; consumed = 1'b0; run_start = 1'b0;
        for (int i = 0; i < 3; i++) res[i] = f_res(K_END, '0, '0, E_NONE, '0);

        if (eot) begin
            if (!r_halt) begin
                case (r_mode)
                    M_WHI: begin
                        if (r_bsp) begin
                            if (r_nest == '0) begin
                                res[cnt] = f_res(K_WHI, r_estart, pos_prev, E_NONE, '0);
                                cnt = cnt + 2'd1;
                                res[cnt] = f_res(K_TOK, pos_prev, r_pos, E_NONE, '0);
                                cnt = cnt + 2'd1;
                            end
                        end else if (r_nest == '0) begin
                            res[cnt] = f_res(K_WHI, r_estart, r_pos, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                    M_TOK, M_SLASH, M_PRE, M_LCO: begin
                        if (r_nest == '0) begin
                            res[cnt] = f_res((r_mode == M_PRE) ? K_PRE :
                                             (r_mode == M_LCO) ? K_LCO : K_TOK,
                                             r_estart, r_pos, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                    M_STR, M_CHR, M_BCO: begin
                        res[cnt] = f_res(K_ERR, r_estart, r_pos,
                                         (r_mode == M_STR) ? E_STRING :
                                         (r_mode == M_CHR) ? E_CHAR : E_COMMENT, r_isl);
                        cnt = cnt + 2'd1;
                    end
                    default: ;
                endcase
                if (!(r_mode == M_STR || r_mode == M_CHR || r_mode == M_BCO)
                        && r_nest != '0) begin
                    res[cnt] = f_res(K_ERR, r_estart, r_pos, E_OPEN,
                                     r_top[LINE_BITS-1:0]);
                    cnt = cnt + 2'd1;
                end
            end
            res[cnt] = f_res(K_END, r_pos, r_pos, E_NONE, '0);
            cnt = cnt + 2'd1;
            n_mode = M_IDLE; n_lsf = 1'b1; n_esc = 1'b0; n_bsp = 1'b0; n_star = 1'b0;
            n_halt = 1'b0; n_nest = '0; n_pos = '0; n_line = LINE_BITS'(1);
            n_estart = '0; n_isl = LINE_BITS'(1);
        end else if (!r_halt) begin
            case (r_mode)
                M_WHI: begin
                    if (r_bsp) begin
                        n_bsp = 1'b0;
                        if (c == C_NL) begin
                            consumed = 1'b1;
                        end else begin
                            if (r_nest == '0) begin
                                res[cnt] = f_res(K_WHI, r_estart, pos_prev, E_NONE, '0);
                                cnt = cnt + 2'd1;
                                n_estart = pos_prev;
                            end
                            n_lsf = 1'b0;
                            n_mode = M_TOK;
                        end
                    end else if (c == C_SP || c == C_TAB) begin
                        consumed = 1'b1;
                    end else if (c == C_BSL) begin
                        n_bsp = 1'b1;
                        consumed = 1'b1;
                    end else begin
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_WHI, r_estart, r_pos, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end
                end
                M_TOK: begin
                    consumed = 1'b0;
                end
                M_PRE: begin
                    consumed = 1'b1;
                    if (r_bsp && c == C_NL) begin
                        n_bsp = 1'b0;
                    end else if (c == C_NL) begin
                        n_bsp = 1'b0;
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_PRE, r_estart, r_pos, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                        consumed = 1'b0;
                    end else begin
                        n_bsp = (c == C_BSL);
                    end
                end
                M_SLASH: begin
                    if (c == C_SLASH) begin
                        n_lsf = 1'b0;
                        n_mode = M_LCO;
                        consumed = 1'b1;
                    end else if (c == C_STAR) begin
                        n_star = 1'b0;
                        n_mode = M_BCO;
                        consumed = 1'b1;
                    end else begin
                        n_lsf = 1'b0;
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_TOK, r_estart, r_pos, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end
                end
                M_LCO: begin
                    if (c != C_NL) begin
                        consumed = 1'b1;
                    end else begin
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_LCO, r_estart, r_pos, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end
                end
                M_BCO: begin
                    consumed = 1'b1;
                    if (r_star && c == C_SLASH) begin
                        n_star = 1'b0;
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_BCO, r_estart, pos_end, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end else begin
                        n_star = (c == C_STAR);
                    end
                end
                M_STR, M_CHR: begin
                    consumed = 1'b1;
                    if (!r_esc && c == ((r_mode == M_STR) ? C_DQ : C_SQ)) begin
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_TOK, r_estart, pos_end, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end else begin
                        n_esc = (c == C_BSL) ? !r_esc : 1'b0;
                    end
                end
                default: begin
                    run_start = 1'b1;
                end
            endcase

            if (!consumed && n_mode == M_TOK) begin
                if (!f_tok_stop(c)) begin
                    consumed = 1'b1;
                end else begin
                    if (r_nest == '0) begin
                        res[cnt] = f_res(K_TOK, n_estart, r_pos, E_NONE, '0);
                        cnt = cnt + 2'd1;
                    end
                    n_mode = M_IDLE;
                end
            end
            if (!consumed) run_start = 1'b1;

            if (run_start) begin
                n_mode = M_IDLE;
                if (r_nest == '0) n_estart = r_pos;
                n_isl = r_line;
                case (c)
                    C_NL: begin
                        n_lsf = 1'b1;
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_LBR, r_pos, pos_end, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                    C_STAR: begin
                        if (r_nest == '0) begin
                            res[cnt] = f_res(n_lsf ? K_PUB : K_TOK, r_pos, pos_end,
                                             E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                    C_SEMI, C_EQ: begin
                        n_lsf = 1'b0;
                        if (r_nest == '0) begin
                            res[cnt] = f_res((c == C_SEMI) ? K_SEM : K_ASG, r_pos, pos_end,
                                             E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                    C_HASH: begin
                        if (n_lsf) begin
                            n_lsf = 1'b0;
                            n_bsp = 1'b0;
                            n_mode = M_PRE;
                        end else if (r_nest == '0) begin
                            res[cnt] = f_res(K_TOK, r_pos, pos_end, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                    C_SP, C_TAB: begin
                        n_bsp = 1'b0;
                        n_mode = M_WHI;
                    end
                    C_DQ, C_SQ: begin
                        n_lsf = 1'b0;
                        n_esc = 1'b0;
                        n_mode = (c == C_DQ) ? M_STR : M_CHR;
                    end
                    C_SLASH: begin
                        n_mode = M_SLASH;
                    end
                    C_LPAR, C_LBRC, C_LBRK: begin
                        n_lsf = 1'b0;
                        if (r_nest >= NEST_W'(NEST_DEPTH)) begin
                            res[cnt] = f_res(K_ERR, n_estart, pos_end, E_OVERFLOW, r_line);
                            cnt = cnt + 2'd1;
                            n_halt = 1'b1;
                        end else begin
                            push = 1'b1;
                            n_top = push_data;
                            n_nest = r_nest + 1'b1;
                        end
                    end
                    C_RPAR, C_RBRC, C_RBRK: begin
                        n_lsf = 1'b0;
                        if (r_nest == '0) begin
                            res[cnt] = f_res(K_CLO, r_pos, pos_end, E_NONE, '0);
                            cnt = cnt + 2'd1;
                        end else if (r_top[BR_W-1:LINE_BITS] == bc) begin
                            n_nest = r_nest - 1'b1;
                            n_top = r_below;
                            if (n_nest == '0) begin
                                res[cnt] = f_res(f_group_kind(bc), r_estart, pos_end,
                                                 E_NONE, '0);
                                cnt = cnt + 2'd1;
                            end
                        end else begin
                            res[cnt] = f_res(K_ERR, r_estart, pos_end, E_MISMATCH, r_line);
                            cnt = cnt + 2'd1;
                            n_halt = 1'b1;
                        end
                    end
                    default: begin
                        n_lsf = 1'b0;
                        n_mode = M_TOK;
                    end
                endcase
            end
            if (c == C_NL) n_line = (r_line < LIN_MAX) ? r_line + 1'b1 : LIN_MAX;
            n_pos = pos_end;
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
    end

    assign rd_addr = (in_fire ? n_nest : r_nest) - NEST_W'(2);

    always_ff @(posedge i_clk) begin
        if (in_fire && push) r_stack[r_nest[ADDR_W-1:0]] <= push_data;
        r_below <= r_stack[rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_lsf <= 1'b1; r_esc <= 1'b0; r_bsp <= 1'b0;
            r_star <= 1'b0; r_halt <= 1'b0; r_nest <= '0; r_pos <= '0;
            r_line <= LINE_BITS'(1); r_estart <= '0; r_isl <= LINE_BITS'(1);
        end else if (in_fire) begin
            r_mode <= n_mode; r_lsf <= n_lsf; r_esc <= n_esc; r_bsp <= n_bsp;
            r_star <= n_star; r_halt <= n_halt; r_nest <= n_nest; r_pos <= n_pos;
            r_line <= n_line; r_estart <= n_estart; r_isl <= n_isl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_top <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < cnt) r_q[r_wp + 2'(i)] <= res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (in_fire) r_wp <= r_wp + cnt;
            if (out_fire) r_rp <= r_rp + 2'd1;
            r_count <= r_count + (in_fire ? {1'b0, cnt} : 3'd0) - {2'b00, out_fire};
        end
    end

    assign i_in.ready         = (r_count <= 3'd1);
    assign o_out.valid        = (r_count != 3'd0);
    assign o_out.kind         = r_q[r_rp].kind;
    assign o_out.begin_offset = r_q[r_rp].beg;
    assign o_out.length       = r_q[r_rp].len;
    assign o_out.error_code   = r_q[r_rp].code;
    assign o_out.error_line   = r_q[r_rp].line;
    assign o_out.last         = r_q[r_rp].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("result queue overrun");

    a_eot_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && eot |=> r_nest == '0 && r_mode == M_IDLE && !r_halt && r_pos == '0)
        else $error("scanner not rearmed after end of text");

    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && eot |-> cnt != 2'd0) else $error("end of text gave no result");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_halt && !eot |-> cnt == 2'd0) else $error("result after error");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_pos)) else $error("offset moved without a beat");

endmodule

/* dv/cses_checker.sv */
module cses_checker
    import cses_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cses_in_if          i_in,
    cses_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_err_seen
);

    localparam int          DEPTH   = NEST_DEPTH_DEF;
    localparam int unsigned OFF_MAX = (1 << OFFSET_BITS_DEF) - 1;
    localparam int unsigned LIN_MAX = (1 << LINE_BITS_DEF) - 1;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] begin_offset;
        logic [23:0] length;
        t_err        code;
        logic [19:0] line;
        logic        last;
    } t_element;

    t_element    element_q[$];
    t_element    step_buf[3];
    int          step_cnt;

    t_mode       mode;
    bit          at_line_start, in_escape, bsl_pending, after_star, halted;
    int unsigned depth_now, cur_pos, cur_line, elem_begin, open_line;
    logic [1:0]  opener_code[DEPTH];
    int unsigned opener_line[DEPTH];

    function automatic int unsigned sat(int unsigned v, int unsigned max);
        return v < max ? v + 1 : max;
    endfunction

    function automatic void clear_scan();
        mode = M_IDLE;
        at_line_start = 1;
        in_escape = 0;
        bsl_pending = 0;
        after_star = 0;
        halted = 0;
        depth_now = 0;
        cur_pos = 0;
        cur_line = 1;
        elem_begin = 0;
        open_line = 1;
    endfunction

    function automatic void add(t_kind k, int unsigned b, int unsigned e, t_err code,
                                int unsigned ln);
        t_element r;
        int unsigned len;
        if (step_cnt >= 3) return;
        len = e >= b ? e - b : 0;
        if (len > OFF_MAX) len = OFF_MAX;
        r.kind = k;
        r.begin_offset = b[23:0];
        r.length = len[23:0];
        r.code = code;
        r.line = ln[19:0];
        r.last = 0;
        step_buf[step_cnt] = r;
        step_cnt++;
    endfunction

    function automatic void top_elem(t_kind k, int unsigned b, int unsigned e);
        if (depth_now == 0) add(k, b, e, E_NONE, 0);
    endfunction

    function automatic void raise(t_err code, int unsigned ln, int unsigned e);
        add(K_ERR, elem_begin, e, code, ln);
        halted = 1;
    endfunction

    function automatic bit ends_token(logic [7:0] c);
        return c inside {C_SP, C_TAB, C_NL, C_SEMI, C_EQ, C_SLASH, C_BSL, C_DQ, C_SQ,
                         C_LPAR, C_LBRC, C_LBRK, C_RPAR, C_RBRC, C_RBRK};
    endfunction

    function automatic logic [1:0] pair_of(logic [7:0] c);
        if (c == C_LPAR || c == C_RPAR) return BR_PAR;
        if (c == C_LBRK || c == C_RBRK) return BR_BRA;
        return BR_CUR;
    endfunction

    function automatic void open_element(logic [7:0] c, int unsigned p, int unsigned ln);
        int unsigned e;
        t_kind gk;
        e = sat(p, OFF_MAX);
        if (depth_now == 0) elem_begin = p;
        open_line = ln;
        case (c)
            C_NL: begin
                at_line_start = 1;
                top_elem(K_LBR, p, e);
            end
            C_STAR: top_elem(at_line_start ? K_PUB : K_TOK, p, e);
            C_SEMI: begin
                at_line_start = 0;
                top_elem(K_SEM, p, e);
            end
            C_EQ: begin
                at_line_start = 0;
                top_elem(K_ASG, p, e);
            end
            C_HASH: begin
                if (at_line_start) begin
                    at_line_start = 0;
                    bsl_pending = 0;
                    mode = M_PRE;
                end else begin
                    top_elem(K_TOK, p, e);
                end
            end
            C_SP, C_TAB: begin
                bsl_pending = 0;
                mode = M_WHI;
            end
            C_DQ, C_SQ: begin
                at_line_start = 0;
                in_escape = 0;
                mode = c == C_DQ ? M_STR : M_CHR;
            end
            C_SLASH: mode = M_SLASH;
            C_LPAR, C_LBRC, C_LBRK: begin
                at_line_start = 0;
                if (depth_now >= DEPTH) begin
                    raise(E_OVERFLOW, ln, e);
                end else begin
                    opener_code[depth_now] = pair_of(c);
                    opener_line[depth_now] = ln;
                    depth_now++;
                end
            end
            C_RPAR, C_RBRC, C_RBRK: begin
                at_line_start = 0;
                if (depth_now == 0) begin
                    top_elem(K_CLO, p, e);
                end else if (opener_code[depth_now - 1] == pair_of(c)) begin
                    depth_now--;
                    case (pair_of(c))
                        BR_PAR:  gk = K_PAR;
                        BR_BRA:  gk = K_BRA;
                        default: gk = K_CUR;
                    endcase
                    top_elem(gk, elem_begin, e);
                end else begin
                    raise(E_MISMATCH, ln, e);
                end
            end
            default: begin
                at_line_start = 0;
                mode = M_TOK;
            end
        endcase
    endfunction

    // Returns 1 when the byte belongs to the current element.
    function automatic bit absorb(logic [7:0] c, int unsigned p, int unsigned ln);
        int unsigned prev;
        prev = p ? p - 1 : 0;
        case (mode)
            M_WHI: begin
                if (bsl_pending) begin
                    bsl_pending = 0;
                    if (c == C_NL) return 1;
                    top_elem(K_WHI, elem_begin, prev);
                    if (depth_now == 0) elem_begin = prev;
                    at_line_start = 0;
                    mode = M_TOK;
                    return 0;
                end
                if (c == C_SP || c == C_TAB) return 1;
                if (c == C_BSL) begin
                    bsl_pending = 1;
                    return 1;
                end
                top_elem(K_WHI, elem_begin, p);
                mode = M_IDLE;
                return 0;
            end
            M_TOK: begin
                if (!ends_token(c)) return 1;
                top_elem(K_TOK, elem_begin, p);
                mode = M_IDLE;
                return 0;
            end
            M_PRE: begin
                if (bsl_pending) begin
                    bsl_pending = 0;
                    if (c == C_NL) return 1;
                end
                if (c == C_NL) begin
                    top_elem(K_PRE, elem_begin, p);
                    mode = M_IDLE;
                    return 0;
                end
                if (c == C_BSL) bsl_pending = 1;
                return 1;
            end
            M_SLASH: begin
                if (c == C_SLASH) begin
                    at_line_start = 0;
                    mode = M_LCO;
                    return 1;
                end
                if (c == C_STAR) begin
                    after_star = 0;
                    mode = M_BCO;
                    return 1;
                end
                at_line_start = 0;
                top_elem(K_TOK, elem_begin, p);
                mode = M_IDLE;
                return 0;
            end
            M_LCO: begin
                if (c != C_NL) return 1;
                top_elem(K_LCO, elem_begin, p);
                mode = M_IDLE;
                return 0;
            end
            M_BCO: begin
                if (after_star && c == C_SLASH) begin
                    after_star = 0;
                    top_elem(K_BCO, elem_begin, sat(p, OFF_MAX));
                    mode = M_IDLE;
                    return 1;
                end
                after_star = c == C_STAR;
                return 1;
            end
            M_STR, M_CHR: begin
                if (!in_escape && c == (mode == M_STR ? C_DQ : C_SQ)) begin
                    top_elem(K_TOK, elem_begin, sat(p, OFF_MAX));
                    mode = M_IDLE;
                    return 1;
                end
                in_escape = c == C_BSL ? !in_escape : 0;
                return 1;
            end
            default: begin
                mode = M_IDLE;
                open_element(c, p, ln);
                return 1;
            end
        endcase
    endfunction

    function automatic void close_text();
        int unsigned p, prev;
        bit bad;
        p = cur_pos;
        prev = p ? p - 1 : 0;
        bad = 0;
        if (!halted) begin
            case (mode)
                M_WHI: begin
                    if (bsl_pending) begin
                        top_elem(K_WHI, elem_begin, prev);
                        top_elem(K_TOK, prev, p);
                    end else begin
                        top_elem(K_WHI, elem_begin, p);
                    end
                end
                M_TOK, M_SLASH: top_elem(K_TOK, elem_begin, p);
                M_PRE: top_elem(K_PRE, elem_begin, p);
                M_LCO: top_elem(K_LCO, elem_begin, p);
                M_STR: begin
                    raise(E_STRING, open_line, p);
                    bad = 1;
                end
                M_CHR: begin
                    raise(E_CHAR, open_line, p);
                    bad = 1;
                end
                M_BCO: begin
                    raise(E_COMMENT, open_line, p);
                    bad = 1;
                end
                default: ;
            endcase
            if (!bad && depth_now > 0) raise(E_OPEN, opener_line[depth_now - 1], p);
        end
        add(K_END, p, p, E_NONE, 0);
        clear_scan();
    endfunction

    function automatic void scan_beat(logic [7:0] c, logic eot);
        step_cnt = 0;
        if (eot || c == C_NUL) begin
            close_text();
        end else if (!halted) begin
            for (int i = 0; i < 4 && !halted; i++)
                if (absorb(c, cur_pos, cur_line)) break;
            if (c == C_NL) cur_line = sat(cur_line, LIN_MAX);
            cur_pos = sat(cur_pos, OFF_MAX);
        end
        for (int i = 0; i < step_cnt; i++) begin
            if (i == step_cnt - 1) step_buf[i].last = 1;
            element_q.push_back(step_buf[i]);
        end
    endfunction

    initial begin
        clear_scan();
    end

    always @(posedge i_clk) begin
        t_element want;
        if (!i_rst_n) begin
            clear_scan();
            element_q.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_err_seen = 0;
            o_pending <= 0;
        end else begin
            if (i_in.valid && i_in.ready) scan_beat(i_in.text_byte, i_in.end_of_text);
            if (i_out.valid && i_out.ready) begin
                o_checked++;
                if (i_out.kind == K_ERR) o_err_seen++;
                if (element_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result beat kind=%0d begin=%0d len=%0d",
                                 i_out.kind, i_out.begin_offset, i_out.length);
                end else begin
                    want = element_q.pop_front();
                    if (i_out.kind !== want.kind || i_out.begin_offset !== want.begin_offset ||
                        i_out.length !== want.length || i_out.error_code !== want.code ||
                        i_out.error_line !== want.line || i_out.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected k=%0d b=%0d l=%0d e=%0d ln=%0d last=%0b",
                                     want.kind, want.begin_offset, want.length, want.code,
                                     want.line, want.last,
                                     "  got k=%0d b=%0d l=%0d e=%0d ln=%0d last=%0b",
                                     i_out.kind, i_out.begin_offset, i_out.length,
                                     i_out.error_code, i_out.error_line, i_out.last);
                    end
                end
            end
            o_pending <= element_q.size();
        end
    end

endmodule

/* dv/c_source_element_scanner_tb.sv */
module c_source_element_scanner_tb;
    import cses_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DEPTH_PLUS  = NEST_DEPTH_DEF + 1;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, checked, err_seen;
    int   cycles;
    int   sender_idle, receiver_stall;
    int   beats_sent, texts_sent;
    byte  text_q[$];

    cses_in_if  in_if();
    cses_out_if #(.OFF_W(OFFSET_BITS_DEF), .LINE_W(LINE_BITS_DEF)) out_if();

    c_source_element_scanner i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    cses_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_err_seen   (err_seen)
    );

    initial begin
        i_clk = 0;
        in_if.valid = 0;
        in_if.text_byte = 0;
        in_if.end_of_text = 0;
        out_if.ready = 0;
        cycles = 0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        out_if.ready <= ($urandom_range(99) >= receiver_stall);
        if (cycles > CYCLE_LIMIT) begin
            $display("c_source_element_scanner_tb: FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic [7:0] b, logic eot);
        while ($urandom_range(99) < sender_idle) begin
            in_if.valid <= 0;
            @(posedge i_clk);
        end
        in_if.valid <= 1;
        in_if.text_byte <= b;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (!in_if.ready);
        beats_sent++;
    endtask

    task automatic send_text(bit by_nul);
        foreach (text_q[i]) send_beat(text_q[i], 0);
        if (by_nul) send_beat(C_NUL, 0);
        else send_beat(8'($urandom_range(255)), 1);
        in_if.valid <= 0;
        text_q.delete();
        texts_sent++;
    endtask

    task automatic put(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic put_fragment(bit allow_bad);
        int pick;
        pick = $urandom_range(allow_bad ? 19 : 15);
        case (pick)
            0: repeat ($urandom_range(1, 4)) text_q.push_back(byte'($urandom_range(97, 122)));
            1: repeat ($urandom_range(1, 3)) text_q.push_back($urandom_range(1) ? " " : "\t");
            2: put(" \\\n ");
            3: put(" \\x");
            4: put("\n#def a \\\n b\n");
            5: put("// c*\n");
            6: put("/* a**b */");
            7: put("\"a\\\\\\\"b\"");
            8: put("'\\''");
            9: put("(a[b]{c;=})");
            10: put($urandom_range(1) ? ";" : "=");
            11: put("\n*x*");
            12: text_q.push_back(byte'($urandom_range(1, 255)));
            13: put($urandom_range(1) ? ")" : "]}");
            14: put("a/b");
            15: put("{\n(x\n)}");
            16: put("/* open");
            17: put("\"open");
            18: put("(\n[}");
            19: put($urandom_range(1) ? "'x" : "{\n[");
            default: ;
        endcase
    endtask

    task automatic set_phase(int s, int r);
        sender_idle = s;
        receiver_stall = r;
    endtask

    initial begin
        int n;
        sender_idle = 0;
        receiver_stall = 0;
        beats_sent = 0;
        texts_sent = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        put("*x = 'a';\n");
        send_text(0);
        put("\t#/*");
        send_text(0);
        put("\"ab");
        send_text(1);
        put("{(");
        send_text(0);
        put(" \\");
        send_text(0);
        put("a(]");
        send_text(0);

        @(posedge i_clk);
        wait (pending == 0);
        repeat (5) @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_phase(0, 0);
                1: set_phase(59, 0);
                2: set_phase(0, 59);
                default: set_phase(21, 21);
            endcase
            n = beats_sent + 45;
            while (beats_sent < n) begin
                repeat ($urandom_range(1, 8)) put_fragment($urandom_range(4) == 0);
                send_text($urandom_range(7) == 0);
            end
            if (ph == 1) begin
                repeat (DEPTH_PLUS) text_q.push_back(C_LPAR);
                send_text(0);
            end
        end

        set_phase(0, 0);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d beats in %0d texts; checked %0d result beats, %0d of them errors.",
                 beats_sent, texts_sent, checked, err_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("c_source_element_scanner_tb: PASS");
        end else begin
            $display("c_source_element_scanner_tb: FAIL");
        end
        $finish;
    end

endmodule

/* c_source_element_scanner.f */
design/cses_pkg.sv
design/cses_in_if.sv
design/cses_out_if.sv
design/c_source_element_scanner.sv
dv/cses_checker.sv
dv/c_source_element_scanner_tb.sv
